// ===== hdl/nps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the non-preemptive priority scheduler.
// No dependencies; used by every module of the block.
package nps_pkg;

    localparam int MAX_JOBS_DEF = 64;
    localparam int ARR_W        = 16;
    localparam int BURST_W      = 16;
    localparam int PRIO_W       = 8;
    localparam int TIME_W       = 24;
    localparam int SUM_W        = 32;
    localparam int ID_W         = 7;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SCAN = 4'b0010,
        S_CALC = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        ST_FINISH = 3'd0,
        ST_TURN   = 3'd1,
        ST_WAIT   = 3'd2,
        ST_SUM_T  = 3'd3,
        ST_SUM_W  = 3'd4,
        ST_GAP    = 3'd5,
        ST_IDLE   = 3'd6
    } calc_step_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_t;

endpackage

// ===== hdl/nps_alu.sv =====
`timescale 1ns / 1ps
// Shared add/subtract unit stepped by the scheduler sequencer.
// Depends on nps_pkg.
module nps_alu
(
    input  nps_pkg::alu_req_t           req,
    output logic [nps_pkg::SUM_W-1:0]   y
);

    always_comb
    begin
        unique case (req.op)
            nps_pkg::ALU_ADD: y = req.a + req.b;
            nps_pkg::ALU_SUB: y = req.a - req.b;
        endcase
    end

endmodule

// ===== hdl/nps_job_mem.sv =====
`timescale 1ns / 1ps
// Job descriptor memory and per-job done bits, one write and one registered read port.
// Depends on nps_pkg.
module nps_job_mem #(
    parameter int DEPTH = nps_pkg::MAX_JOBS_DEF,
    parameter int IDX_W = 6
)
(
    input  logic              clk,
    input  logic              wr_job_en,
    input  logic              wr_done_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  nps_pkg::job_t     wr_job,
    input  logic              wr_done,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output nps_pkg::job_t     rd_job,
    output logic              rd_done
);

    nps_pkg::job_t job_mem [DEPTH];
    logic          done_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_job_en)
        begin
            job_mem[wr_addr] <= wr_job;
        end
        if (wr_done_en)
        begin
            done_mem[wr_addr] <= wr_done;
        end
        if (rd_en)
        begin
            rd_job  <= job_mem[rd_addr];
            rd_done <= done_mem[rd_addr];
        end
    end

endmodule

// ===== hdl/nonpreemptive_priority_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Non-preemptive priority scheduler: job loader, scan sequencer and result register.
// Depends on nps_pkg, nps_job_mem and nps_alu.
//
// Usage:
//   Job channel (job_valid/job_stall): one descriptor beat per cycle while loading.
//   A beat with last set closes the set and starts scheduling; job_stall stays
//   high until the final result of the set has been placed in the output register.
//   Descriptors beyond MAX_JOBS are dropped, but their last mark still counts.
//   Result channel (result_valid/result_stall): one beat per job, in run order,
//   last_result set on the final one. The output register holds a stalled beat.
//   Per result, N jobs in the set: one scan reads the job memory through its
//   one read port, one entry per cycle; a second scan follows when no job is
//   ready and time jumps forward; then the shared adder steps through finish,
//   turnaround, wait, the two sums, gap and idle, and the output register is
//   loaded once the receiver is not stalling with a beat still held.
//   Reset: asynchronous, active low; the block comes up empty and loading.
//   The job memory is not cleared; every entry read was written in its set.
module nonpreemptive_priority_scheduler_unit #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_stall,
    input  logic [nps_pkg::ARR_W-1:0]     arrival_tick,
    input  logic [nps_pkg::BURST_W-1:0]   burst_len,
    input  logic [nps_pkg::PRIO_W-1:0]    priority_req,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [nps_pkg::ID_W-1:0]      job_id,
    output logic [nps_pkg::TIME_W-1:0]    start_tick,
    output logic [nps_pkg::TIME_W-1:0]    finish_tick,
    output logic [nps_pkg::TIME_W-1:0]    turnaround_len,
    output logic [nps_pkg::TIME_W-1:0]    wait_len,
    output logic [nps_pkg::SUM_W-1:0]     total_turnaround,
    output logic [nps_pkg::SUM_W-1:0]     total_waiting,
    output logic [nps_pkg::TIME_W-1:0]    idle_time,
    output logic [nps_pkg::ID_W-1:0]      job_count,
    output logic                          last_result
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TW    = nps_pkg::TIME_W;
    localparam int SW    = nps_pkg::SUM_W;
    localparam int AW    = nps_pkg::ARR_W;
    localparam int BW    = nps_pkg::BURST_W;
    localparam int PW    = nps_pkg::PRIO_W;
    localparam int IW    = nps_pkg::ID_W;

    nps_pkg::state_t     state_reg, state_next;
    nps_pkg::calc_step_t step_reg, step_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic [TW-1:0]    prev_reg, prev_next;
    logic             first_reg, first_next;
    logic [SW-1:0]    sum_t_reg, sum_t_next;
    logic [SW-1:0]    sum_w_reg, sum_w_next;
    logic [TW-1:0]    sum_i_reg, sum_i_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             found_reg, found_next;
    logic             early_valid_reg, early_valid_next;

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [AW-1:0]    best_arr_reg, best_arr_next;
    logic [BW-1:0]    best_burst_reg, best_burst_next;
    logic [PW-1:0]    best_prio_reg, best_prio_next;
    logic [AW-1:0]    early_reg, early_next;
    logic [TW-1:0]    finish_reg, finish_next;
    logic [TW-1:0]    turn_reg, turn_next;
    logic [TW-1:0]    wait_reg, wait_next;
    logic [TW-1:0]    gap_reg, gap_next;

    logic             out_valid_reg, out_valid_next;
    logic [IW-1:0]    out_id_reg, out_id_next;
    logic [TW-1:0]    out_start_reg, out_start_next;
    logic [TW-1:0]    out_comp_reg, out_comp_next;
    logic [TW-1:0]    out_turn_reg, out_turn_next;
    logic [TW-1:0]    out_wait_reg, out_wait_next;
    logic [SW-1:0]    out_tot_t_reg, out_tot_t_next;
    logic [SW-1:0]    out_tot_w_reg, out_tot_w_next;
    logic [TW-1:0]    out_idle_reg, out_idle_next;
    logic [IW-1:0]    out_cnt_reg, out_cnt_next;
    logic             out_last_reg, out_last_next;

    logic             mem_wr_job_en;
    logic             mem_wr_done_en;
    logic [IDX_W-1:0] mem_wr_addr;
    nps_pkg::job_t    mem_wr_job;
    logic             mem_wr_done;
    logic             mem_rd_en;
    nps_pkg::job_t    mem_rd_job;
    logic             mem_rd_done;

    nps_pkg::alu_req_t alu_req;
    logic [SW-1:0]     alu_y;

    logic             job_accept;
    logic             out_free;
    logic             entry_pend;
    logic             entry_ready;
    logic             entry_better;
    logic             entry_take;
    logic             entry_early;
    logic             scan_end;
    logic             set_last;
    logic [SW-1:0]    id_wide;
    logic [SW-1:0]    cnt_wide;

    nps_job_mem #(
        .DEPTH (MAX_JOBS),
        .IDX_W (IDX_W)
    ) u_nps_job_mem (
        .clk        (clk),
        .wr_job_en  (mem_wr_job_en),
        .wr_done_en (mem_wr_done_en),
        .wr_addr    (mem_wr_addr),
        .wr_job     (mem_wr_job),
        .wr_done    (mem_wr_done),
        .rd_en      (mem_rd_en),
        .rd_addr    (scan_addr_reg[IDX_W-1:0]),
        .rd_job     (mem_rd_job),
        .rd_done    (mem_rd_done)
    );

    nps_alu u_nps_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign job_stall  = (state_reg != nps_pkg::S_LOAD);
    assign job_accept = job_valid && !job_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    assign entry_pend   = rd_valid_reg && !mem_rd_done;
    assign entry_ready  = entry_pend && (TW'(mem_rd_job.arrival) <= tick_reg);
    assign entry_better = !found_reg || (mem_rd_job.prio > best_prio_reg)
                          || ((mem_rd_job.prio == best_prio_reg)
                              && (mem_rd_job.arrival < best_arr_reg));
    assign entry_take   = entry_ready && entry_better;
    assign entry_early  = entry_pend && (!early_valid_reg || (mem_rd_job.arrival < early_reg));
    assign scan_end     = rd_valid_reg && (CNT_W'(rd_idx_reg) == (count_reg - 1'b1));
    assign set_last     = ((emitted_reg + 1'b1) == count_reg);
    assign id_wide      = SW'(best_idx_reg) + SW'(1);
    assign cnt_wide     = SW'(count_reg);

    always_comb
    begin
        alu_req.op = nps_pkg::ALU_ADD;
        alu_req.a  = SW'(tick_reg);
        alu_req.b  = SW'(best_burst_reg);
        unique case (step_reg)
            nps_pkg::ST_FINISH:
            begin
                alu_req.op = nps_pkg::ALU_ADD;
                alu_req.a  = SW'(tick_reg);
                alu_req.b  = SW'(best_burst_reg);
            end
            nps_pkg::ST_TURN:
            begin
                alu_req.op = nps_pkg::ALU_SUB;
                alu_req.a  = SW'(finish_reg);
                alu_req.b  = SW'(best_arr_reg);
            end
            nps_pkg::ST_WAIT:
            begin
                alu_req.op = nps_pkg::ALU_SUB;
                alu_req.a  = SW'(turn_reg);
                alu_req.b  = SW'(best_burst_reg);
            end
            nps_pkg::ST_SUM_T:
            begin
                alu_req.op = nps_pkg::ALU_ADD;
                alu_req.a  = sum_t_reg;
                alu_req.b  = SW'(turn_reg);
            end
            nps_pkg::ST_SUM_W:
            begin
                alu_req.op = nps_pkg::ALU_ADD;
                alu_req.a  = sum_w_reg;
                alu_req.b  = SW'(wait_reg);
            end
            nps_pkg::ST_GAP:
            begin
                alu_req.op = nps_pkg::ALU_SUB;
                alu_req.a  = SW'(tick_reg);
                alu_req.b  = SW'(prev_reg);
            end
            nps_pkg::ST_IDLE:
            begin
                alu_req.op = nps_pkg::ALU_ADD;
                alu_req.a  = SW'(sum_i_reg);
                alu_req.b  = SW'(gap_reg);
            end
            default:
            begin
                alu_req.op = nps_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        emitted_next     = emitted_reg;
        scan_addr_next   = scan_addr_reg;
        tick_next        = tick_reg;
        prev_next        = prev_reg;
        first_next       = first_reg;
        sum_t_next       = sum_t_reg;
        sum_w_next       = sum_w_reg;
        sum_i_next       = sum_i_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = scan_addr_reg[IDX_W-1:0];
        found_next       = found_reg;
        early_valid_next = early_valid_reg;
        best_idx_next    = best_idx_reg;
        best_arr_next    = best_arr_reg;
        best_burst_next  = best_burst_reg;
        best_prio_next   = best_prio_reg;
        early_next       = early_reg;
        finish_next      = finish_reg;
        turn_next        = turn_reg;
        wait_next        = wait_reg;
        gap_next         = gap_reg;

        out_valid_next   = out_valid_reg && result_stall;
        out_id_next      = out_id_reg;
        out_start_next   = out_start_reg;
        out_comp_next    = out_comp_reg;
        out_turn_next    = out_turn_reg;
        out_wait_next    = out_wait_reg;
        out_tot_t_next   = out_tot_t_reg;
        out_tot_w_next   = out_tot_w_reg;
        out_idle_next    = out_idle_reg;
        out_cnt_next     = out_cnt_reg;
        out_last_next    = out_last_reg;

        mem_wr_job_en    = 1'b0;
        mem_wr_done_en   = 1'b0;
        mem_wr_addr      = count_reg[IDX_W-1:0];
        mem_wr_job       = '{arrival: arrival_tick, burst: burst_len, prio: priority_req};
        mem_wr_done      = 1'b0;
        mem_rd_en        = 1'b0;

        unique case (state_reg)
            nps_pkg::S_LOAD:
            begin
                if (job_accept)
                begin
                    if (count_reg < CNT_W'(MAX_JOBS))
                    begin
                        mem_wr_job_en  = 1'b1;
                        mem_wr_done_en = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                    if (last)
                    begin
                        state_next       = nps_pkg::S_SCAN;
                        scan_addr_next   = '0;
                        found_next       = 1'b0;
                        early_valid_next = 1'b0;
                    end
                end
            end
            nps_pkg::S_SCAN:
            begin
                if (scan_addr_reg < count_reg)
                begin
                    mem_rd_en      = 1'b1;
                    rd_valid_next  = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (entry_take)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_arr_next   = mem_rd_job.arrival;
                    best_burst_next = mem_rd_job.burst;
                    best_prio_next  = mem_rd_job.prio;
                end
                if (entry_early)
                begin
                    early_valid_next = 1'b1;
                    early_next       = mem_rd_job.arrival;
                end
                if (scan_end)
                begin
                    rd_valid_next  = 1'b0;
                    scan_addr_next = '0;
                    if (found_reg || entry_take)
                    begin
                        state_next = nps_pkg::S_CALC;
                        step_next  = nps_pkg::ST_FINISH;
                    end
                    else
                    begin
                        // jump to the earliest pending arrival and rescan
                        tick_next        = TW'(early_next);
                        found_next       = 1'b0;
                        early_valid_next = 1'b0;
                    end
                end
            end
            nps_pkg::S_CALC:
            begin
                unique case (step_reg)
                    nps_pkg::ST_FINISH:
                    begin
                        finish_next = alu_y[TW-1:0];
                        step_next   = nps_pkg::ST_TURN;
                    end
                    nps_pkg::ST_TURN:
                    begin
                        turn_next = alu_y[TW-1:0];
                        step_next = nps_pkg::ST_WAIT;
                    end
                    nps_pkg::ST_WAIT:
                    begin
                        wait_next = alu_y[TW-1:0];
                        step_next = nps_pkg::ST_SUM_T;
                    end
                    nps_pkg::ST_SUM_T:
                    begin
                        sum_t_next = alu_y;
                        step_next  = nps_pkg::ST_SUM_W;
                    end
                    nps_pkg::ST_SUM_W:
                    begin
                        sum_w_next = alu_y;
                        step_next  = nps_pkg::ST_GAP;
                    end
                    nps_pkg::ST_GAP:
                    begin
                        gap_next  = alu_y[TW-1:0];
                        step_next = nps_pkg::ST_IDLE;
                    end
                    nps_pkg::ST_IDLE:
                    begin
                        if (!first_reg)
                        begin
                            sum_i_next = alu_y[TW-1:0];
                        end
                        step_next  = nps_pkg::ST_FINISH;
                        state_next = nps_pkg::S_EMIT;
                    end
                    default:
                    begin
                        step_next = nps_pkg::ST_FINISH;
                    end
                endcase
            end
            nps_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = id_wide[IW-1:0];
                    out_start_next = tick_reg;
                    out_comp_next  = finish_reg;
                    out_turn_next  = turn_reg;
                    out_wait_next  = wait_reg;
                    out_tot_t_next = sum_t_reg;
                    out_tot_w_next = sum_w_reg;
                    out_idle_next  = sum_i_reg;
                    out_cnt_next   = cnt_wide[IW-1:0];
                    out_last_next  = set_last;

                    mem_wr_done_en = 1'b1;
                    mem_wr_addr    = best_idx_reg;
                    mem_wr_done    = 1'b1;

                    if (set_last)
                    begin
                        state_next   = nps_pkg::S_LOAD;
                        count_next   = '0;
                        emitted_next = '0;
                        tick_next    = '0;
                        prev_next    = '0;
                        first_next   = 1'b1;
                        sum_t_next   = '0;
                        sum_w_next   = '0;
                        sum_i_next   = '0;
                    end
                    else
                    begin
                        state_next       = nps_pkg::S_SCAN;
                        emitted_next     = emitted_reg + 1'b1;
                        tick_next        = finish_reg;
                        prev_next        = finish_reg;
                        first_next       = 1'b0;
                        scan_addr_next   = '0;
                        found_next       = 1'b0;
                        early_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = nps_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nps_pkg::S_LOAD;
            step_reg        <= nps_pkg::ST_FINISH;
            count_reg       <= '0;
            emitted_reg     <= '0;
            scan_addr_reg   <= '0;
            tick_reg        <= '0;
            prev_reg        <= '0;
            first_reg       <= 1'b1;
            sum_t_reg       <= '0;
            sum_w_reg       <= '0;
            sum_i_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            early_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            count_reg       <= count_next;
            emitted_reg     <= emitted_next;
            scan_addr_reg   <= scan_addr_next;
            tick_reg        <= tick_next;
            prev_reg        <= prev_next;
            first_reg       <= first_next;
            sum_t_reg       <= sum_t_next;
            sum_w_reg       <= sum_w_next;
            sum_i_reg       <= sum_i_next;
            rd_valid_reg    <= rd_valid_next;
            found_reg       <= found_next;
            early_valid_reg <= early_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_arr_reg   <= best_arr_next;
        best_burst_reg <= best_burst_next;
        best_prio_reg  <= best_prio_next;
        early_reg      <= early_next;
        finish_reg     <= finish_next;
        turn_reg       <= turn_next;
        wait_reg       <= wait_next;
        gap_reg        <= gap_next;
        out_id_reg     <= out_id_next;
        out_start_reg  <= out_start_next;
        out_comp_reg   <= out_comp_next;
        out_turn_reg   <= out_turn_next;
        out_wait_reg   <= out_wait_next;
        out_tot_t_reg  <= out_tot_t_next;
        out_tot_w_reg  <= out_tot_w_next;
        out_idle_reg   <= out_idle_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign result_valid     = out_valid_reg;
    assign job_id           = out_id_reg;
    assign start_tick       = out_start_reg;
    assign finish_tick      = out_comp_reg;
    assign turnaround_len   = out_turn_reg;
    assign wait_len         = out_wait_reg;
    assign total_turnaround = out_tot_t_reg;
    assign total_waiting    = out_tot_w_reg;
    assign idle_time        = out_idle_reg;
    assign job_count        = out_cnt_reg;
    assign last_result      = out_last_reg;

endmodule

// ===== hdl/nps_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the scheduler, bound to the top level.
// Depends on nps_pkg and nonpreemptive_priority_scheduler_unit.
module nps_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          job_valid,
    input logic                          job_stall,
    input logic                          last,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [nps_pkg::ID_W-1:0]      job_id,
    input logic [nps_pkg::TIME_W-1:0]    start_tick,
    input logic [nps_pkg::TIME_W-1:0]    finish_tick,
    input logic [nps_pkg::ID_W-1:0]      job_count,
    input logic                          last_result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(job_id)
            && $stable(start_tick) && $stable(finish_tick) && $stable(last_result))
        else $error("stalled result beat changed");

    a_id_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (job_id != '0) && (job_id <= job_count))
        else $error("job id outside the loaded set");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall && last |=> job_stall)
        else $error("input not stalled after the closing job beat");

    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(job_stall))
        else $error("result appeared while the block was loading");

endmodule

bind nonpreemptive_priority_scheduler_unit nps_checker u_nps_checker (.*);
